// ===== sv/crm_pkg.sv =====
package crm_pkg;

    // Curve points per segment and derived widths
    localparam int SEGMENTS = 20;
    localparam int S_W      = $clog2(SEGMENTS + 1);
    localparam int COORD_W  = 16;
    localparam int WGT_W    = 17;
    localparam int PROD_W   = COORD_W + WGT_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int FRAC_W   = 15;

    // Weight denominator 2*n^3 and its half, for round half away from zero
    localparam longint WDEN  = 2 * SEGMENTS * SEGMENTS * SEGMENTS;
    localparam longint WHALF = WDEN / 2;
    localparam longint WONE  = 32768;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [WGT_W-1:0]   weight_t;
    typedef weight_t [3:0]             wset_t;
    typedef wset_t [SEGMENTS:0]        wtable_t;
    typedef logic [S_W-1:0]            sidx_t;

    // Microprogram step addresses
    typedef enum logic [2:0] {
        PC_IDLE  = 3'd0,
        PC_MOVE  = 3'd1,
        PC_SEG1  = 3'd2,
        PC_SHIFT = 3'd3,
        PC_SEG2  = 3'd4
    } pc_t;

    // Operand sets fed to the multipliers
    typedef enum logic [1:0] {
        SRC_MOVE = 2'd0,   // new point in all four slots
        SRC_SEG1 = 2'd1,   // older, prev, cur, new
        SRC_SEG2 = 2'd2    // older, prev, cur, cur (flush)
    } src_t;

    // Jump kinds
    typedef enum logic [1:0] {
        J_WAIT    = 2'd0,  // wait for a request, then dispatch on points seen
        J_GOTO    = 2'd1,
        J_LOOP    = 2'd2,  // repeat with s+1 until s reaches SEGMENTS
        J_IF_LAST = 2'd3   // to target if end of stroke, else idle
    } jump_t;

    // How run_last is marked
    typedef enum logic [1:0] {
        RL_NONE     = 2'd0,
        RL_ALWAYS   = 2'd1,
        RL_AT_END   = 2'd2,
        RL_END_NOFL = 2'd3 // at end of loop only when no flush follows
    } rl_t;

    typedef struct packed {
        logic  emit;
        src_t  src;
        logic  is_move;
        rl_t   rl;
        logic  load_first;
        logic  shift;
        jump_t jump;
        pc_t   target;
    } uword_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic  take;
        logic  issue;
        src_t  src;
        logic  is_move;
        logic  run_last;
        logic  load_first;
        logic  shift;
        sidx_t widx;
    } ctrl_t;

    // Control store
    function automatic uword_t ucode(pc_t pc);
        uword_t w;
        w.emit       = 1'b0;
        w.src        = SRC_MOVE;
        w.is_move    = 1'b0;
        w.rl         = RL_NONE;
        w.load_first = 1'b0;
        w.shift      = 1'b0;
        w.jump       = J_WAIT;
        w.target     = PC_IDLE;
        unique case (pc)
            PC_IDLE:
            begin
                w.jump = J_WAIT;
            end
            PC_MOVE:
            begin
                w.emit       = 1'b1;
                w.src        = SRC_MOVE;
                w.is_move    = 1'b1;
                w.rl         = RL_ALWAYS;
                w.load_first = 1'b1;
                w.jump       = J_GOTO;
                w.target     = PC_IDLE;
            end
            PC_SEG1:
            begin
                w.emit   = 1'b1;
                w.src    = SRC_SEG1;
                w.rl     = RL_END_NOFL;
                w.jump   = J_LOOP;
                w.target = PC_SHIFT;
            end
            PC_SHIFT:
            begin
                w.shift  = 1'b1;
                w.jump   = J_IF_LAST;
                w.target = PC_SEG2;
            end
            PC_SEG2:
            begin
                w.emit   = 1'b1;
                w.src    = SRC_SEG2;
                w.rl     = RL_AT_END;
                w.jump   = J_LOOP;
                w.target = PC_IDLE;
            end
            default:
            begin
                w.jump   = J_GOTO;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    // round(32768 * num / WDEN), half away from zero
    function automatic longint wround(longint num);
        longint q;
        if (num >= 0)
            q = (num * WONE + WHALF) / WDEN;
        else
            q = -((-num * WONE + WHALF) / WDEN);
        return q;
    endfunction

    // Blend weights for t = s/SEGMENTS; entry 0 passes the second point
    function automatic wtable_t build_weights();
        wtable_t tb;
        longint  n;
        longint  s;
        longint  r;
        n = SEGMENTS;
        for (int i = 0; i <= SEGMENTS; i++)
        begin
            s = i;
            r = n - s;
            tb[i][0] = WGT_W'(wround(-s * r * r));
            tb[i][1] = WGT_W'(wround(3 * s * s * s - 5 * s * s * n + 2 * n * n * n));
            tb[i][2] = WGT_W'(wround(-3 * s * s * s + 4 * s * s * n + s * n * n));
            tb[i][3] = WGT_W'(wround(-s * s * r));
        end
        return tb;
    endfunction

    localparam wtable_t W_TABLE = build_weights();

endpackage

// ===== sv/crm_sequencer.sv =====
module crm_sequencer
    import crm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  eos,
    input  logic  adv,
    output logic  busy,
    output ctrl_t ctrl
);

    pc_t        pc_reg, pc_next;
    sidx_t      s_reg, s_next;
    logic [1:0] seen_reg;
    logic       last_reg;
    uword_t     word;
    logic       at_end;
    logic       step_en;

    // Decode current control word
    always_comb
    begin
        word   = ucode(pc_reg);
        at_end = (s_reg == S_W'(SEGMENTS));

        ctrl.take       = accept;
        ctrl.issue      = word.emit;
        ctrl.src        = word.src;
        ctrl.is_move    = word.is_move;
        ctrl.load_first = word.load_first;
        ctrl.shift      = word.shift;
        ctrl.widx       = s_reg;
        unique case (word.rl)
            RL_NONE:     ctrl.run_last = 1'b0;
            RL_ALWAYS:   ctrl.run_last = 1'b1;
            RL_AT_END:   ctrl.run_last = at_end;
            RL_END_NOFL: ctrl.run_last = at_end && !last_reg;
            default:     ctrl.run_last = 1'b0;
        endcase
    end

    assign busy    = (pc_reg != PC_IDLE);
    assign step_en = (word.jump == J_WAIT) ? 1'b1 : adv;

    // Next step address and loop counter
    always_comb
    begin
        pc_next = pc_reg;
        s_next  = s_reg;
        unique case (word.jump)
            J_WAIT:
            begin
                if (accept)
                begin
                    priority if (seen_reg == 2'd0)
                    begin
                        pc_next = PC_MOVE;
                        s_next  = '0;
                    end
                    else if (seen_reg == 2'd1)
                    begin
                        pc_next = PC_SHIFT;
                    end
                    else
                    begin
                        pc_next = PC_SEG1;
                        s_next  = S_W'(1);
                    end
                end
            end
            J_GOTO:
            begin
                pc_next = word.target;
            end
            J_LOOP:
            begin
                if (at_end)
                    pc_next = word.target;
                else
                    s_next = s_reg + S_W'(1);
            end
            J_IF_LAST:
            begin
                if (last_reg)
                begin
                    pc_next = word.target;
                    s_next  = S_W'(1);
                end
                else
                begin
                    pc_next = PC_IDLE;
                end
            end
            default:
            begin
                pc_next = PC_IDLE;
            end
        endcase
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
            s_reg  <= '0;
        end
        else if (step_en)
        begin
            pc_reg <= pc_next;
            s_reg  <= s_next;
        end
    end

    // Stroke position, updated per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 2'd0;
            last_reg <= 1'b0;
        end
        else if (accept)
        begin
            last_reg <= eos;
            if (eos)
                seen_reg <= 2'd0;
            else if (seen_reg != 2'd3)
                seen_reg <= seen_reg + 2'd1;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pc_reg != PC_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_loop_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_SEG1 || pc_reg == PC_SEG2) |->
            (s_reg != '0 && s_reg <= S_W'(SEGMENTS)))
        else $error("segment loop counter out of range");

    a_flush_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_SEG2) |-> last_reg)
        else $error("flush segment without end of stroke");

endmodule

// ===== sv/crm_datapath.sv =====
module crm_datapath
    import crm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  ctrl_t  ctrl,
    input  logic   adv,
    input  coord_t point_x,
    input  coord_t point_y,
    output logic   curve_valid,
    output coord_t curve_x,
    output coord_t curve_y,
    output logic   is_move,
    output logic   run_last
);

    coord_t new_x_reg, new_y_reg;
    coord_t older_x_reg, older_y_reg;
    coord_t prev_x_reg, prev_y_reg;
    coord_t cur_x_reg, cur_y_reg;

    coord_t               ox [4];
    coord_t               oy [4];
    wset_t                wt;
    logic signed [PROD_W-1:0] px_next [4];
    logic signed [PROD_W-1:0] py_next [4];
    logic signed [PROD_W-1:0] px_reg  [4];
    logic signed [PROD_W-1:0] py_reg  [4];
    logic                 v1_reg;
    logic                 mv1_reg;
    logic                 rl1_reg;

    logic signed [ACC_W-1:0] acc_x, acc_y;
    coord_t                  sat_x, sat_y;

    logic   valid_reg;
    coord_t cx_reg, cy_reg;
    logic   mv_reg, rl_reg;

    // Rounded shift by 15 fraction bits with saturation
    function automatic coord_t scale_sat(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]        r;
        logic signed [ACC_W-FRAC_W-1:0] q;
        coord_t                         res;
        r = v + ACC_W'(1 << (FRAC_W - 1));
        q = (ACC_W-FRAC_W)'(r >>> FRAC_W);
        if (q > (ACC_W-FRAC_W)'(32767))
            res = 16'sh7FFF;
        else if (q < -(ACC_W-FRAC_W)'(32768))
            res = 16'sh8000;
        else
            res = COORD_W'(q);
        return res;
    endfunction

    // Incoming point
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            new_x_reg <= point_x;
            new_y_reg <= point_y;
        end
    end

    // Control point window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_x_reg <= '0;
            older_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
        end
        else if (adv && ctrl.load_first)
        begin
            older_x_reg <= new_x_reg;
            older_y_reg <= new_y_reg;
            prev_x_reg  <= new_x_reg;
            prev_y_reg  <= new_y_reg;
            cur_x_reg   <= new_x_reg;
            cur_y_reg   <= new_y_reg;
        end
        else if (adv && ctrl.shift)
        begin
            older_x_reg <= prev_x_reg;
            older_y_reg <= prev_y_reg;
            prev_x_reg  <= cur_x_reg;
            prev_y_reg  <= cur_y_reg;
            cur_x_reg   <= new_x_reg;
            cur_y_reg   <= new_y_reg;
        end
    end

    // Operand select and weight lookup
    always_comb
    begin
        unique case (ctrl.src)
            SRC_MOVE:
            begin
                ox = '{new_x_reg, new_x_reg, new_x_reg, new_x_reg};
                oy = '{new_y_reg, new_y_reg, new_y_reg, new_y_reg};
            end
            SRC_SEG1:
            begin
                ox = '{older_x_reg, prev_x_reg, cur_x_reg, new_x_reg};
                oy = '{older_y_reg, prev_y_reg, cur_y_reg, new_y_reg};
            end
            SRC_SEG2:
            begin
                ox = '{older_x_reg, prev_x_reg, cur_x_reg, cur_x_reg};
                oy = '{older_y_reg, prev_y_reg, cur_y_reg, cur_y_reg};
            end
            default:
            begin
                ox = '{new_x_reg, new_x_reg, new_x_reg, new_x_reg};
                oy = '{new_y_reg, new_y_reg, new_y_reg, new_y_reg};
            end
        endcase
        wt = W_TABLE[ctrl.widx];
        for (int i = 0; i < 4; i++)
        begin
            px_next[i] = PROD_W'(wt[i]) * PROD_W'(ox[i]);
            py_next[i] = PROD_W'(wt[i]) * PROD_W'(oy[i]);
        end
    end

    // Product stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            mv1_reg <= ctrl.is_move;
            rl1_reg <= ctrl.run_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= ctrl.issue;
    end

    // Sum of products, round and saturate
    always_comb
    begin
        acc_x = ACC_W'(px_reg[0]) + ACC_W'(px_reg[1]) + ACC_W'(px_reg[2]) + ACC_W'(px_reg[3]);
        acc_y = ACC_W'(py_reg[0]) + ACC_W'(py_reg[1]) + ACC_W'(py_reg[2]) + ACC_W'(py_reg[3]);
        sat_x = scale_sat(acc_x);
        sat_y = scale_sat(acc_y);
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg <= sat_x;
            cy_reg <= sat_y;
            mv_reg <= mv1_reg;
            rl_reg <= rl1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= v1_reg;
    end

    assign curve_valid = valid_reg;
    assign curve_x     = cx_reg;
    assign curve_y     = cy_reg;
    assign is_move     = mv_reg;
    assign run_last    = rl_reg;

    a_move_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && mv_reg) |-> rl_reg)
        else $error("move-to result not marked last of run");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv) |=> v1_reg)
        else $error("product stage dropped a result while frozen");

endmodule

// ===== sv/catmull_rom_interpolator.sv =====
// Channel  Valid         Stall         Payload
// point    point_valid   point_stall   point_x, point_y, end_of_stroke
// curve    curve_valid   curve_stall   curve_x, curve_y, is_move, run_last
//
// The idle step takes the request, then one step runs per result plus a
// shift step for each point but the first: a first point gives a move-to,
// a second shifts and flushes if it ends the stroke, a later one gives a
// segment, shifts, flushes if last. Results pass product and output regs.
// The step rate is set by the single shared multiply stage (8 products).
// Reset clears the step counter, point window and stroke count.
// A stalled valid result freezes the sequencer steps and both pipeline
// stages; an idle sequencer still takes a request under stall.
module catmull_rom_interpolator
    import crm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    output logic   point_stall,
    input  coord_t point_x,
    input  coord_t point_y,
    input  logic   end_of_stroke,
    output logic   curve_valid,
    input  logic   curve_stall,
    output coord_t curve_x,
    output coord_t curve_y,
    output logic   is_move,
    output logic   run_last
);

    ctrl_t ctrl;
    logic  busy;
    logic  accept;
    logic  adv;

    // Request handshake and pipeline advance
    assign point_stall = busy;
    assign accept      = point_valid && !busy;
    assign adv         = !(curve_valid && curve_stall);

    crm_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .eos    (end_of_stroke),
        .adv    (adv),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    crm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .adv         (adv),
        .point_x     (point_x),
        .point_y     (point_y),
        .curve_valid (curve_valid),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .is_move     (is_move),
        .run_last    (run_last)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import crm_pkg::*;

    localparam int N = SEGMENTS;

    // One expected curve point
    typedef struct {
        coord_t x;
        coord_t y;
        logic   mv;
        logic   last;
    } curve_pt_t;

    // Stroke predictor and queue of curve points still owed by the block
    class curve_scoreboard;
        longint     wt[N+1][4];
        coord_t     old_x, old_y, mid_x, mid_y, cur_x, cur_y;
        logic [1:0] seen;
        curve_pt_t  owed_q[$];
        int         errors;

        function new();
            longint den;
            longint r;
            den = 2 * N * N * N;
            for (int s = 1; s <= N; s++)
            begin
                r = N - s;
                wt[s][0] = q15(-s * r * r, den);
                wt[s][1] = q15(3 * s * s * s - 5 * s * s * N + 2 * N * N * N, den);
                wt[s][2] = q15(-3 * s * s * s + 4 * s * s * N + s * N * N, den);
                wt[s][3] = q15(-s * s * r, den);
            end
            old_x = '0; old_y = '0;
            mid_x = '0; mid_y = '0;
            cur_x = '0; cur_y = '0;
            seen   = '0;
            errors = 0;
        endfunction

        // Q2.15 weight, half away from zero
        function longint q15(longint num, longint den);
            longint mag;
            mag = (num < 0) ? -num : num;
            mag = (mag * 32768 + den / 2) / den;
            return (num < 0) ? -mag : mag;
        endfunction

        // Drop 15 fraction bits (half up), clamp to 16 bits
        function coord_t settle(longint acc);
            longint q;
            q = (acc + 16384) >>> 15;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return coord_t'(q);
        endfunction

        function void push_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                   coord_t cx, coord_t cy, coord_t dx, coord_t dy);
            curve_pt_t p;
            longint    sx;
            longint    sy;
            for (int s = 1; s <= N; s++)
            begin
                sx = wt[s][0] * ax + wt[s][1] * bx + wt[s][2] * cx + wt[s][3] * dx;
                sy = wt[s][0] * ay + wt[s][1] * by + wt[s][2] * cy + wt[s][3] * dy;
                p.x    = settle(sx);
                p.y    = settle(sy);
                p.mv   = 1'b0;
                p.last = 1'b0;
                owed_q.push_back(p);
            end
        endfunction

        // Accepted control point: work out the curve points it causes
        function void note_point(coord_t x, coord_t y, logic eos);
            int        base;
            curve_pt_t p;
            base = owed_q.size();
            if (seen == 2'd0)
            begin
                p.x    = x;
                p.y    = y;
                p.mv   = 1'b1;
                p.last = 1'b0;
                owed_q.push_back(p);
                old_x = x; mid_x = x; cur_x = x;
                old_y = y; mid_y = y; cur_y = y;
            end
            else
            begin
                if (seen >= 2'd2)
                    push_segment(old_x, old_y, mid_x, mid_y, cur_x, cur_y, x, y);
                old_x = mid_x; old_y = mid_y;
                mid_x = cur_x; mid_y = cur_y;
                cur_x = x;     cur_y = y;
                // end mark flushes the closing segment
                if (eos)
                    push_segment(old_x, old_y, mid_x, mid_y, cur_x, cur_y, cur_x, cur_y);
            end
            if (seen != 2'd3)
                seen = seen + 2'd1;
            if (eos)
                seen = 2'd0;
            if (owed_q.size() > base)
                owed_q[owed_q.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            if (errors < 30)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_curve(coord_t x, coord_t y, logic mv, logic last);
            curve_pt_t e;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected curve point x=%0d y=%0d", x, y));
                return;
            end
            e = owed_q.pop_front();
            if (x !== e.x)
                report($sformatf("curve_x got %0d want %0d", x, e.x));
            if (y !== e.y)
                report($sformatf("curve_y got %0d want %0d", y, e.y));
            if (mv !== e.mv)
                report($sformatf("is_move got %b want %b", mv, e.mv));
            if (last !== e.last)
                report($sformatf("run_last got %b want %b", last, e.last));
        endtask

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   point_valid = 1'b0;
    logic   point_stall;
    coord_t point_x = '0;
    coord_t point_y = '0;
    logic   end_of_stroke = 1'b0;
    logic   curve_valid;
    logic   curve_stall = 1'b0;
    coord_t curve_x;
    coord_t curve_y;
    logic   is_move;
    logic   run_last;

    curve_scoreboard sb = new();
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int points_sent = 0;

    catmull_rom_interpolator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_valid),
        .point_stall   (point_stall),
        .point_x       (point_x),
        .point_y       (point_y),
        .end_of_stroke (end_of_stroke),
        .curve_valid   (curve_valid),
        .curve_stall   (curve_stall),
        .curve_x       (curve_x),
        .curve_y       (curve_y),
        .is_move       (is_move),
        .run_last      (run_last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watch both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n && point_valid && !point_stall)
            sb.note_point(point_x, point_y, end_of_stroke);
        if (rst_n && curve_valid && !curve_stall)
            sb.check_curve(curve_x, curve_y, is_move, run_last);
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                curve_stall <= 1'b1;
                repeat (400) @(posedge clk);
                curve_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                curve_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                curve_stall <= 1'b0;
            end
            else
            begin
                curve_stall <= 1'b0;
            end
        end
    end

    // Offer one request and hold it until taken
    task automatic send_point(coord_t x, coord_t y, logic eos);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        point_valid   <= 1'b1;
        point_x       <= x;
        point_y       <= y;
        end_of_stroke <= eos;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        points_sent++;
        if (points_sent >= 170)
            quiet = 1'b1;
    endtask

    function automatic coord_t rand_coord(int mode);
        coord_t c;
        case (mode)
            0: c = coord_t'($urandom);
            1: c = coord_t'($urandom_range(0, 1023)) - coord_t'(512);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: c = 16'sh8000;
                    1: c = 16'sh7fff;
                    2: c = 16'sh0000;
                    default: c = 16'shffff;
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    c = 16'sh7fff - coord_t'($urandom_range(0, 2047));
                else
                    c = 16'sh8000 + coord_t'($urandom_range(0, 2047));
            end
        endcase
        return c;
    endfunction

    task automatic send_stroke(int len, int mode);
        int m;
        for (int i = 0; i < len; i++)
        begin
            m = (mode > 3) ? $urandom_range(0, 3) : mode;
            send_point(rand_coord(m), rand_coord(m), i == len - 1);
        end
    endtask

    // Run timeout
    initial
    begin
        #6_000_000;
        $display("[catmull_rom_interpolator] ERROR");
        $finish;
    end

    initial
    begin
        int len;
        int strokes;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single point strokes at the corners
        send_point(16'sh7fff, 16'sh8000, 1'b1);
        send_point(16'sh8000, 16'sh7fff, 1'b1);
        // two point stroke
        send_point(16'sh0000, 16'sh0000, 1'b0);
        send_point(16'sh0010, -16'sh0010, 1'b1);
        // three point stroke
        send_point(16'sd100, 16'sd200, 1'b0);
        send_point(16'sd300, -16'sd50, 1'b0);
        send_point(-16'sd400, 16'sd600, 1'b1);
        // alternating extremes overshoot and saturate
        send_point(16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh7fff, 16'sh8000, 1'b1);
        // values around zero, rounding at half steps
        send_point(16'shffff, 16'shffff, 1'b0);
        send_point(16'sh0000, 16'sh0000, 1'b0);
        send_point(16'shffff, 16'sh0001, 1'b1);
        // four point stroke, full window
        send_point(-16'sd1000, 16'sd5, 1'b0);
        send_point(16'sd2500, 16'sd1234, 1'b0);
        send_point(16'sd777, -16'sd3210, 1'b0);
        send_point(16'sd12000, -16'sd12000, 1'b1);

        // random strokes, mostly a few points long
        strokes = 0;
        while (points_sent < 210)
        begin
            case ($urandom_range(0, 19))
                0, 1:    len = 1;
                2, 3, 4: len = 2;
                5:       len = $urandom_range(9, 20);
                default: len = $urandom_range(3, 8);
            endcase
            if (strokes == 4)
            begin
                // long hold-off on the curve side while points keep coming
                hold_req = 1'b1;
                len = 10;
            end
            send_stroke(len, $urandom_range(0, 4));
            strokes++;
        end
        point_valid   <= 1'b0;
        end_of_stroke <= 1'b0;

        // drain, then give stray results time to show up
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (2 * N + 10) @(posedge clk);
        if (sb.owed() != 0)
            sb.report($sformatf("%0d curve points never came", sb.owed()));

        if (sb.errors == 0)
            $display("[catmull_rom_interpolator] OK");
        else
            $display("[catmull_rom_interpolator] ERROR");
        $finish;
    end

endmodule
